// ===== design/scgm_pkg.sv =====
// Shared types and constants for the speed class group merger.
package scgm_pkg;

	localparam int DEF_NODES  = 16;
	localparam int DEF_GROUPS = 64;

	localparam int MODE_W   = 2;
	localparam int NODE_W   = 4;
	localparam int BW_W     = 32;
	localparam int RIDX_W   = 6;
	localparam int CLASS_W  = 7;
	localparam int LAND_W   = 6;
	localparam int MEMB_W   = 16;
	localparam int TOTAL_W  = 7;
	localparam int TOL_W    = 16;

	localparam logic [TOL_W-1:0]   TOL_RESET = 16'd6554;
	localparam logic [CLASS_W-1:0] CLASS_MAX = 7'd127;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD   = 2'd0,
		MODE_READ  = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	// Classified request handed from the front part to the back part.
	typedef struct packed {
		mode_t             mode;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
		logic [RIDX_W-1:0] read_index;
		logic [CLASS_W-1:0] cls;
	} work_t;

	typedef struct packed {
		logic [CLASS_W-1:0] class_id;
		logic [LAND_W-1:0]  landed_group;
		logic [MEMB_W-1:0]  members;
		logic [TOTAL_W-1:0] groups_in_use;
		logic               entry_valid;
		logic               overflowed;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_WRITE,
		ST_REPLY
	} back_state_t;

endpackage

// ===== design/scgm_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface scgm_req_if;
	import scgm_pkg::*;
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [NODE_W-1:0] node_a;
	logic [NODE_W-1:0] node_b;
	logic [BW_W-1:0]   pair_bandwidth;
	logic [RIDX_W-1:0] read_index;
	modport source (output valid, mode, node_a, node_b, pair_bandwidth, read_index,
		input ready);
	modport sink (input valid, mode, node_a, node_b, pair_bandwidth, read_index,
		output ready);
endinterface

interface scgm_res_if;
	import scgm_pkg::*;
	logic               valid;
	logic               ready;
	logic [CLASS_W-1:0] class_id;
	logic [LAND_W-1:0]  landed_group;
	logic [MEMB_W-1:0]  members;
	logic [TOTAL_W-1:0] groups_in_use;
	logic               entry_valid;
	logic               overflowed;
	modport source (output valid, class_id, landed_group, members, groups_in_use,
		entry_valid, overflowed, input ready);
	modport sink (input valid, class_id, landed_group, members, groups_in_use,
		entry_valid, overflowed, output ready);
endinterface

// ===== design/scgm_front.sv =====
// Front part: accepts requests, runs the class test, feeds the work queue.
module scgm_front
	import scgm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [TOL_W-1:0]  tolerance,
	scgm_req_if.sink          req,
	output logic              wvalid,
	input  logic              wready,
	output work_t             wdata
);

	logic [BW_W-1:0]    prev_bw_q;
	logic               seen_q;
	logic [CLASS_W-1:0] class_q;
	logic               busy_q;
	work_t              hold_q;
	logic [BW_W-1:0]    bw_s1;
	logic [BW_W+16:0]   p_s1, lo_s1, hi_s1;
	logic               prod_q;
	logic [CLASS_W-1:0] cls_next;
	logic               out_q;
	logic               stage_q;

	assign req.ready = !busy_q;

	always_comb begin
		cls_next = class_q;
		if (seen_q && (p_s1 < lo_s1 || p_s1 > hi_s1) && class_q != CLASS_MAX)
			cls_next = class_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			hold_q.mode       <= mode_t'(req.mode);
			hold_q.node_a     <= req.node_a;
			hold_q.node_b     <= req.node_b;
			hold_q.read_index <= req.read_index;
			bw_s1             <= req.pair_bandwidth;
		end
		p_s1  <= {1'b0, prev_bw_q, 16'd0};
		lo_s1 <= (BW_W+17)'(bw_s1) * (BW_W+17)'(17'h10000 - {1'b0, tolerance});
		hi_s1 <= (BW_W+17)'(bw_s1) * (BW_W+17)'(17'h10000 + {1'b0, tolerance});
		if (prod_q && hold_q.mode == MODE_ADD)
			hold_q.cls <= cls_next;
		else if (prod_q)
			hold_q.cls <= '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			prod_q    <= 1'b0;
			out_q     <= 1'b0;
			prev_bw_q <= '0;
			seen_q    <= 1'b0;
			class_q   <= '0;
		end else begin
			prod_q <= 1'b0;
			if (req.valid && req.ready) begin
				busy_q <= 1'b1;
			end
			if (prod_q) begin
				out_q <= 1'b1;
				unique case (hold_q.mode)
					MODE_ADD: begin
						class_q   <= cls_next;
						prev_bw_q <= bw_s1;
						seen_q    <= 1'b1;
					end
					MODE_CLEAR: begin
						class_q   <= '0;
						prev_bw_q <= '0;
						seen_q    <= 1'b0;
					end
					default: ;
				endcase
			end
			if (out_q && wready) begin
				out_q  <= 1'b0;
				busy_q <= 1'b0;
			end
			if (busy_q && !out_q && !prod_q && stage_q)
				prod_q <= 1'b1;
		end
	end

	// Delay the class step until the products are formed from the held bandwidth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stage_q <= 1'b0;
		else
			stage_q <= (req.valid && req.ready);
	end

	assign wvalid = out_q;
	assign wdata  = hold_q;

endmodule

// ===== design/scgm_queue.sv =====
// Two-entry queue between the front and back parts.
module scgm_queue
	import scgm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  work_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output work_t out_data
);

	work_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign in_ready  = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			mem_q[wp_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (in_valid && in_ready)
				wp_q <= !wp_q;
			if (out_valid && out_ready)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
		end
	end

endmodule

// ===== design/scgm_back.sv =====
// Back part: group table memory, merge and compaction sweep, result register.
module scgm_back
	import scgm_pkg::*;
#(
	parameter int NODES  = DEF_NODES,
	parameter int GROUPS = DEF_GROUPS
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wvalid,
	output logic   wready,
	input  work_t  wdata,
	scgm_res_if.source res
);

	localparam int GI_W = $clog2(GROUPS);
	localparam int GT_W = $clog2(GROUPS + 1);

	logic [NODES-1:0]   mem_m [GROUPS];
	logic [CLASS_W-1:0] mem_c [GROUPS];
	logic [NODES-1:0]   rd_m_q;
	logic [CLASS_W-1:0] rd_c_q;

	back_state_t        state_q, state_d;
	work_t              cur_q;
	logic [GT_W-1:0]    total_q;
	logic [GT_W-1:0]    ri_q, wi_q;
	logic               found_q;
	logic [GI_W-1:0]    first_q;
	logic [NODES-1:0]   acc_q;
	logic               rd_pend_q;
	logic               res_valid_q;
	result_t            res_q;

	logic [NODES-1:0]   pair;
	logic               hit;
	logic [GI_W-1:0]    rd_addr;
	logic               we;
	logic [GI_W-1:0]    wa;
	logic [NODES-1:0]   wm;
	logic [CLASS_W-1:0] wc;

	always_comb begin
		pair = '0;
		if (32'(cur_q.node_a) < NODES)
			pair[cur_q.node_a[$clog2(NODES)-1:0]] = 1'b1;
		if (32'(cur_q.node_b) < NODES)
			pair[cur_q.node_b[$clog2(NODES)-1:0]] = 1'b1;
	end

	assign hit = rd_c_q == cur_q.cls && (rd_m_q & pair) != '0;

	always_ff @(posedge clk) begin
		rd_m_q <= mem_m[rd_addr];
		rd_c_q <= mem_c[rd_addr];
		if (we) begin
			mem_m[wa] <= wm;
			mem_c[wa] <= wc;
		end
	end

	assign wready = state_q == ST_IDLE && !res_valid_q;

	always_comb begin
		state_d = state_q;
		rd_addr = ri_q[GI_W-1:0];
		we = 1'b0;
		wa = wi_q[GI_W-1:0];
		wm = rd_m_q;
		wc = rd_c_q;
		unique case (state_q)
			ST_IDLE: begin
				rd_addr = wdata.read_index[GI_W-1:0];
				if (wvalid && wready) begin
					priority if (wdata.mode == MODE_READ) state_d = ST_READ;
					else if (wdata.mode == MODE_ADD) state_d = ST_SCAN;
					else state_d = ST_REPLY;
				end
			end
			ST_READ: state_d = ST_REPLY;
			ST_SCAN: begin
				if (rd_pend_q) begin
					if (hit && found_q) begin
					end else if (hit) begin
						we = 1'b1;
						wm = rd_m_q | pair;
					end else begin
						we = 1'b1;
					end
				end
				if (pair == '0 || (ri_q >= total_q && !rd_pend_q))
					state_d = ST_WRITE;
			end
			ST_WRITE: begin
				we = pair != '0 && (found_q || total_q < GT_W'(GROUPS));
				wa = found_q ? first_q : total_q[GI_W-1:0];
				wm = found_q ? acc_q : pair;
				wc = cur_q.cls;
				state_d = ST_REPLY;
			end
			ST_REPLY: if (!res_valid_q || res.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		if (state_q == ST_REPLY) state_d = ST_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= '0;
			res_valid_q <= 1'b0;
			rd_pend_q   <= 1'b0;
			found_q     <= 1'b0;
			ri_q        <= '0;
			wi_q        <= '0;
		end else begin
			state_q <= state_d;
			if (res_valid_q && res.ready)
				res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (wvalid && wready) begin
						cur_q     <= wdata;
						ri_q      <= '0;
						wi_q      <= '0;
						found_q   <= 1'b0;
						rd_pend_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					rd_pend_q <= ri_q < total_q;
					if (ri_q < total_q) ri_q <= ri_q + 1'b1;
					if (rd_pend_q) begin
						if (hit && found_q) begin
							acc_q <= acc_q | rd_m_q;
						end else if (hit) begin
							found_q <= 1'b1;
							first_q <= wi_q[GI_W-1:0];
							acc_q   <= rd_m_q | pair;
							wi_q    <= wi_q + 1'b1;
						end else begin
							wi_q <= wi_q + 1'b1;
						end
					end
				end
				ST_WRITE: begin
					res_q.class_id <= cur_q.cls;
					res_q.entry_valid <= 1'b0;
					res_q.overflowed <= 1'b0;
					res_q.landed_group <= '0;
					res_q.members <= '0;
					if (pair == '0) begin
					end else if (found_q) begin
						total_q <= wi_q;
						res_q.landed_group <= LAND_W'(first_q);
						res_q.members <= MEMB_W'(acc_q);
						res_q.entry_valid <= 1'b1;
						res_q.groups_in_use <= TOTAL_W'(wi_q);
					end else if (total_q < GT_W'(GROUPS)) begin
						total_q <= total_q + 1'b1;
						res_q.landed_group <= LAND_W'(total_q);
						res_q.members <= MEMB_W'(pair);
						res_q.entry_valid <= 1'b1;
					end else begin
						res_q.overflowed <= 1'b1;
					end
					if (!(pair != '0 && found_q))
						res_q.groups_in_use <= TOTAL_W'(total_q + GT_W'(pair != '0
							&& !found_q && total_q < GT_W'(GROUPS)));
					res_valid_q <= 1'b1;
				end
				ST_READ: begin
					res_q.landed_group <= cur_q.read_index;
					res_q.overflowed <= 1'b0;
					res_q.groups_in_use <= TOTAL_W'(total_q);
					if (GT_W'(cur_q.read_index) < total_q && 32'(cur_q.read_index) < GROUPS) begin
						res_q.class_id <= rd_c_q;
						res_q.members <= MEMB_W'(rd_m_q);
						res_q.entry_valid <= 1'b1;
					end else begin
						res_q.class_id <= '0;
						res_q.members <= '0;
						res_q.entry_valid <= 1'b0;
					end
					res_valid_q <= 1'b1;
				end
				default: ;
			endcase
			if (state_q == ST_IDLE && wvalid && wready && wdata.mode != MODE_READ
					&& wdata.mode != MODE_ADD) begin
				res_q <= '0;
				if (wdata.mode == MODE_CLEAR)
					total_q <= '0;
				else
					res_q.groups_in_use <= TOTAL_W'(total_q);
				res_valid_q <= 1'b1;
			end
		end
	end

	assign res.valid         = res_valid_q;
	assign res.class_id      = res_q.class_id;
	assign res.landed_group  = res_q.landed_group;
	assign res.members       = res_q.members;
	assign res.groups_in_use = res_q.groups_in_use;
	assign res.entry_valid   = res_q.entry_valid;
	assign res.overflowed    = res_q.overflowed;

endmodule

// ===== design/speed_class_group_merger_unit.sv =====
// Top level of the speed class group merger.
// Usage:
//   req: valid/ready request channel carrying mode, node_a, node_b,
//   pair_bandwidth and read_index. res: valid/ready result channel, one
//   result per request. cfg_we/cfg_wdata write class_tolerance (Q0.16).
// The result of an add waits for the group table sweep, which compares, merges
//   and compacts one stored entry per cycle; a clear or a read skips the sweep,
//   and so does an add with an empty pair. The group table has one read port
//   and one write port.
// Flow: req.ready drops after each request until its work item enters the queue;
//   one request at a time through the back part; the front part classifies the next
//   request while the back part sweeps, through a two-entry queue.
// Reset clears the group count, the class counter and the tolerance to its
//   default; the table contents are not cleared, and entries past the group
//   count are never used.
// A stalled receiver holds the result register; the back part then waits
//   and the queue fills before req.ready stays low.
module speed_class_group_merger_unit
	import scgm_pkg::*;
#(
	parameter int NODES  = DEF_NODES,
	parameter int GROUPS = DEF_GROUPS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [TOL_W-1:0] cfg_wdata,
	scgm_req_if.sink         req,
	scgm_res_if.source       res
);

	logic [TOL_W-1:0] tol_q;
	logic  f_valid, f_ready, b_valid, b_ready;
	work_t f_data, b_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tol_q <= TOL_RESET;
		else if (cfg_we)
			tol_q <= cfg_wdata;
	end

	scgm_front u_front (
		.clk, .arst_n, .tolerance(tol_q), .req,
		.wvalid(f_valid), .wready(f_ready), .wdata(f_data)
	);

	scgm_queue u_queue (
		.clk, .arst_n,
		.in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
		.out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
	);

	scgm_back #(.NODES(NODES), .GROUPS(GROUPS)) u_back (
		.clk, .arst_n,
		.wvalid(b_valid), .wready(b_ready), .wdata(b_data), .res
	);

endmodule

// ===== design/scgm_checker.sv =====
// Port-level checker for the speed class group merger, with its bind.
module scgm_checker
	import scgm_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input logic [TOTAL_W-1:0] groups_in_use,
	input logic               entry_valid,
	input logic               overflowed,
	input logic [MEMB_W-1:0]  members
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(members))
		else $error("result dropped while stalled");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(entry_valid && overflowed))
		else $error("valid entry flagged as overflow");

	a_mem: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !entry_valid |-> members == '0)
		else $error("members set on invalid entry");

	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && overflowed |-> groups_in_use != '0)
		else $error("overflow with empty table");

endmodule

bind speed_class_group_merger_unit scgm_checker u_scgm_checker (
	.clk(clk), .arst_n(arst_n), .res_valid(res.valid), .res_ready(res.ready),
	.groups_in_use(res.groups_in_use), .entry_valid(res.entry_valid),
	.overflowed(res.overflowed), .members(res.members)
);
